// ===== rtl/ttca_pkg.sv =====
package ttca_pkg;

  localparam int CELLS_DEF   = 64;
  localparam int STAT_W      = 2;
  localparam int COUNT_W     = 8;
  localparam int TOTAL_W     = 8;
  localparam int INDEX_W     = 6;
  localparam int RULE_W      = 12;
  localparam int RULE_MAX    = 2186;
  localparam int RULE_DIGITS = 7;
  localparam int DIGIT_CNT_W = 3;
  // floor(x/3) == (x * 2731) >> 13 for every 12-bit x
  localparam int RECIP3      = 2731;
  localparam int RECIP3_SH   = 13;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam logic [APB_AW-1:0] ADDR_RULE = 3'd0;

  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_EVOLVE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef logic [RULE_DIGITS-1:0][STAT_W-1:0] rule_digits_t;

  typedef struct packed {
    logic init;
    logic evolve;
  } cell_ctl_t;

  typedef struct packed {
    logic               upd;
    logic [STAT_W-1:0]  state;
    logic [COUNT_W-1:0] tally;
  } pipe_pay_t;

  function automatic logic [STAT_W-1:0] rule_pick(input rule_digits_t d,
                                                  input logic [2:0] sum);
    logic [STAT_W-1:0] r;
    r = '0;
    if (sum < 3'(RULE_DIGITS)) begin
      r = d[sum];
    end
    return r;
  endfunction

  function automatic logic digits_ok(input rule_digits_t d);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < RULE_DIGITS; k++) begin
      if (d[k] == 2'd3) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // node count of one level of the binary adder tree
  function automatic int nodes_at(input int cells, input int lvl);
    return (cells + (1 << lvl) - 1) >> lvl;
  endfunction

endpackage

// ===== rtl/ttca_cell.sv =====
module ttca_cell
  import ttca_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_ctl_t          ctl_i,
  input  logic [STAT_W-1:0]  seed_i,
  input  logic [STAT_W-1:0]  left_i,
  input  logic [STAT_W-1:0]  right_i,
  input  rule_digits_t       digits_i,
  output logic [STAT_W-1:0]  status_o,
  output logic [COUNT_W-1:0] count_o,
  output logic [STAT_W-1:0]  next_o
);

  logic [STAT_W-1:0]  status_q, status_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [2:0]         nbr_sum;
  logic [COUNT_W:0]   count_sum;

  always_comb begin
    nbr_sum   = {1'b0, left_i} + {1'b0, status_q} + {1'b0, right_i};
    next_o    = ctl_i.init ? seed_i : rule_pick(digits_i, nbr_sum);
    count_sum = {1'b0, count_q} + (COUNT_W+1)'(next_o);
    status_d  = status_q;
    count_d   = count_q;
    if (ctl_i.init) begin
      status_d = seed_i;
      count_d  = COUNT_W'(seed_i);
    end else if (ctl_i.evolve) begin
      status_d = next_o;
      count_d  = count_sum[COUNT_W] ? {COUNT_W{1'b1}} : count_sum[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= '0;
      count_q  <= '0;
    end else begin
      status_q <= status_d;
      count_q  <= count_d;
    end
  end

  assign status_o = status_q;
  assign count_o  = count_q;

  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.evolve && !ctl_i.init |=> count_q >= $past(count_q))
    else $error("cell count dropped on evolve");

  a_init_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.init |=> status_q == $past(seed_i) && count_q == COUNT_W'($past(seed_i)))
    else $error("cell not seeded on init");

endmodule

// ===== rtl/ttca_rule_dec.sv =====
module ttca_rule_dec
  import ttca_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  logic [RULE_W-1:0] value_i,
  output logic              busy_o,
  output rule_digits_t      digits_o
);

  logic [RULE_W-1:0]      work_q, work_d;
  logic [DIGIT_CNT_W-1:0] cnt_q, cnt_d;
  rule_digits_t           digits_q, digits_d;
  logic [2*RULE_W-1:0]    prod;
  logic [RULE_W-1:0]      quot, three_q, rem;

  // one base-3 digit per cycle, least significant first, shifted in from the top
  always_comb begin
    prod     = work_q * RULE_W'(RECIP3);
    quot     = RULE_W'(prod >> RECIP3_SH);
    three_q  = (quot << 1) + quot;
    rem      = work_q - three_q;
    work_d   = work_q;
    cnt_d    = cnt_q;
    digits_d = digits_q;
    if (wr_i) begin
      work_d = value_i;
      cnt_d  = DIGIT_CNT_W'(RULE_DIGITS);
    end else if (cnt_q != '0) begin
      work_d   = quot;
      cnt_d    = cnt_q - 1'b1;
      digits_d = {rem[STAT_W-1:0], digits_q[RULE_DIGITS-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      digits_q <= '0;
    end else begin
      cnt_q    <= cnt_d;
      digits_q <= digits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  assign busy_o   = (cnt_q != '0);
  assign digits_o = digits_q;

  a_wr_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |=> busy_o)
    else $error("rule decode did not start");

  a_digits_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> digits_ok(digits_q))
    else $error("rule digit out of range");

endmodule

// ===== rtl/ttca_sum_pipe.sv =====
module ttca_sum_pipe
  import ttca_pkg::*;
#(
  parameter int CELLS = CELLS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [STAT_W-1:0]  leaf_i [CELLS],
  input  pipe_pay_t          pay_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [TOTAL_W-1:0] total_sum_o,
  output logic [STAT_W-1:0]  cell_state_o,
  output logic [COUNT_W-1:0] cell_tally_o
);

  localparam int LEVELS = $clog2(CELLS);
  localparam int SW     = $clog2(2 * CELLS + 1);
  localparam int TW     = (SW > TOTAL_W + 1) ? SW : TOTAL_W + 1;

  logic [SW-1:0]      lvl_v  [0:LEVELS][CELLS];
  logic [SW-1:0]      node_d [1:LEVELS][CELLS];
  logic [SW-1:0]      node_q [1:LEVELS][CELLS];
  pipe_pay_t          pay_q  [1:LEVELS];
  logic [1:LEVELS]    v_q;
  logic [1:LEVELS+1]  go;
  logic               out_v_q;
  logic [TOTAL_W-1:0] last_q;
  logic [TOTAL_W-1:0] total_q, state_tot;
  logic [STAT_W-1:0]  state_q;
  logic [COUNT_W-1:0] tally_q;
  logic [TW-1:0]      tot_ext;

  always_comb begin
    for (int j = 0; j < CELLS; j++) begin
      lvl_v[0][j] = SW'(leaf_i[j]);
    end
    for (int s = 1; s <= LEVELS; s++) begin
      for (int j = 0; j < CELLS; j++) begin
        lvl_v[s][j] = node_q[s][j];
      end
    end
    for (int s = 1; s <= LEVELS; s++) begin
      for (int j = 0; j < CELLS; j++) begin
        node_d[s][j] = '0;
        if (j < nodes_at(CELLS, s)) begin
          if (2 * j < CELLS) begin
            node_d[s][j] = lvl_v[s-1][2*j];
          end
          if (2 * j + 1 < CELLS) begin
            node_d[s][j] = node_d[s][j] + lvl_v[s-1][2*j+1];
          end
        end
      end
    end
  end

  // a stage moves on when it is empty or the stage after it moves
  always_comb begin
    go[LEVELS+1] = !out_v_q || !out_stall_i;
    for (int s = LEVELS; s >= 1; s--) begin
      go[s] = !v_q[s] || go[s+1];
    end
  end

  assign stall_o = !go[1];

  always_comb begin
    tot_ext   = TW'(node_q[LEVELS][0]);
    state_tot = (tot_ext > TW'(2**TOTAL_W - 1)) ? {TOTAL_W{1'b1}} : tot_ext[TOTAL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
      last_q  <= '0;
    end else begin
      if (go[1]) begin
        v_q[1] <= valid_i;
      end
      for (int s = 2; s <= LEVELS; s++) begin
        if (go[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
      if (go[LEVELS+1]) begin
        out_v_q <= v_q[LEVELS];
        if (v_q[LEVELS] && pay_q[LEVELS].upd) begin
          last_q <= state_tot;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go[1]) begin
      node_q[1] <= node_d[1];
      pay_q[1]  <= pay_i;
    end
    for (int s = 2; s <= LEVELS; s++) begin
      if (go[s]) begin
        node_q[s] <= node_d[s];
        pay_q[s]  <= pay_q[s-1];
      end
    end
    if (go[LEVELS+1]) begin
      total_q <= pay_q[LEVELS].upd ? state_tot : last_q;
      state_q <= pay_q[LEVELS].state;
      tally_q <= pay_q[LEVELS].tally;
    end
  end

  assign out_valid_o  = out_v_q;
  assign total_sum_o  = total_q;
  assign cell_state_o = state_q;
  assign cell_tally_o = tally_q;

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_q) && out_v_q && out_stall_i |-> stall_o)
    else $error("request taken into a full pipeline");

  a_bubble_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[1] |-> !stall_o)
    else $error("stall with an empty first stage");

endmodule

// ===== rtl/totalistic_cellular_automaton_ring_core.sv =====
// Channel  Dir  Handshake                  Payload
// request  in   in_valid_i / in_stall_o    operation_i, seed_value_i, cell_index_i
// result   out  out_valid_o / out_stall_i  total_sum_o, cell_state_o, cell_tally_o
// config   in   APB psel/penable/pready    paddr, pwdata, prdata (rule_number at 0x0)
//
// One request per cycle unless in_stall_o is high; each result passes through the
// registered adder tree for the status total (one level per stage) and an output register.
// After a rule write the base-3 digit unit works out the rule digits one by one; requests
// wait meanwhile. Reset clears every cell, the rule and the last total at once.
// Empty stages are squeezed out, so the tree stalls requests only when every stage is full.
module totalistic_cellular_automaton_ring_core
  import ttca_pkg::*;
#(
  parameter int CELLS = CELLS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic [STAT_W-1:0]  seed_value_i,
  input  logic [INDEX_W-1:0] cell_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [TOTAL_W-1:0] total_sum_o,
  output logic [STAT_W-1:0]  cell_state_o,
  output logic [COUNT_W-1:0] cell_tally_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  localparam int MID = CELLS / 2;
  localparam int IW  = ($clog2(CELLS) > INDEX_W) ? $clog2(CELLS) : INDEX_W;

  logic [RULE_W-1:0]  rule_q;
  logic               rule_wr;
  logic               dec_busy;
  rule_digits_t       digits;
  logic               pipe_valid, pipe_stall, fire;
  op_e                op;
  cell_ctl_t          ctl;
  logic [STAT_W-1:0]  seed_c;
  logic [STAT_W-1:0]  status [CELLS];
  logic [COUNT_W-1:0] count  [CELLS];
  logic [STAT_W-1:0]  next   [CELLS];
  logic [IW-1:0]      idx_ext;
  pipe_pay_t          pay;

  // configuration
  assign pready  = 1'b1;
  assign rule_wr = psel && penable && pwrite && (paddr == ADDR_RULE)
                   && (pwdata <= APB_DW'(RULE_MAX));
  assign prdata  = (paddr == ADDR_RULE) ? APB_DW'(rule_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_q <= '0;
    end else if (rule_wr) begin
      rule_q <= pwdata[RULE_W-1:0];
    end
  end

  ttca_rule_dec u_rule_dec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (rule_wr),
    .value_i  (pwdata[RULE_W-1:0]),
    .busy_o   (dec_busy),
    .digits_o (digits)
  );

  // request decode
  assign op         = op_e'(operation_i);
  assign pipe_valid = in_valid_i && !dec_busy;
  assign in_stall_o = pipe_stall || dec_busy;
  assign fire       = pipe_valid && !pipe_stall;
  assign seed_c     = (seed_value_i == 2'd3) ? 2'd2 : seed_value_i;

  always_comb begin
    ctl.init   = fire && (op == OP_INIT);
    ctl.evolve = fire && (op == OP_EVOLVE);
  end

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    localparam int L = (i == 0) ? CELLS - 1 : i - 1;
    localparam int R = (i == CELLS - 1) ? 0 : i + 1;
    ttca_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .seed_i   ((i == MID) ? seed_c : '0),
      .left_i   (status[L]),
      .right_i  (status[R]),
      .digits_i (digits),
      .status_o (status[i]),
      .count_o  (count[i]),
      .next_o   (next[i])
    );
  end

  // read port: an index past the ring matches no cell and reads zero
  always_comb begin
    idx_ext   = IW'(cell_index_i);
    pay.upd   = (op == OP_INIT) || (op == OP_EVOLVE);
    pay.state = '0;
    pay.tally = '0;
    if (op == OP_READ) begin
      for (int i = 0; i < CELLS; i++) begin
        if (idx_ext == IW'(i)) begin
          pay.state = status[i];
          pay.tally = count[i];
        end
      end
    end
  end

  ttca_sum_pipe #(
    .CELLS (CELLS)
  ) u_sum_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (pipe_valid),
    .stall_o      (pipe_stall),
    .leaf_i       (next),
    .pay_i        (pay),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .total_sum_o  (total_sum_o),
    .cell_state_o (cell_state_o),
    .cell_tally_o (cell_tally_o)
  );

  a_busy_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_busy |-> in_stall_o)
    else $error("request taken while rule digits are stale");

  a_bad_rule_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (pwdata > APB_DW'(RULE_MAX)) |=> $stable(rule_q))
    else $error("out-of-range rule was stored");

endmodule
